[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on aclk, quiet while aresetn is low.
`define ADBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Clocked on aclk, checked during reset as well.
`define ADBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[rtl/adbm_pkg.sv]
// Shared types, codes and constants of the bus mouse device.
`timescale 1ns / 1ps

package adbm_pkg;

    localparam int ACCUM_WIDTH_DEF = 20;
    localparam int MOTION_W        = 16;
    localparam int MOTION_SEL_W    = 10;
    localparam int SCALE_W         = 8;
    localparam int DELTA_W         = MOTION_SEL_W + SCALE_W + 1;
    localparam int REPLY_MAX       = 8;
    localparam int CNT_W           = $clog2(REPLY_MAX + 1);
    localparam int REPORT_LIMIT    = 63;

    // input item kinds
    localparam logic [1:0] CMD_MOTION = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_BUS    = 2'd2;

    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;

    // bus command decode
    localparam logic [3:0] FLUSH_CODE  = 4'h1;
    localparam logic [1:0] KIND_LISTEN = 2'b10;
    localparam logic [1:0] KIND_TALK   = 2'b11;
    localparam logic [1:0] REG_DATA    = 2'd0;
    localparam logic [1:0] REG_INFO    = 2'd1;
    localparam logic [1:0] REG_ID      = 2'd3;
    localparam logic [3:0] LISTEN_LEN  = 4'd3;

    localparam logic [7:0] D2_SELF_TEST = 8'hFF;
    localparam logic [7:0] D2_ADDR_A    = 8'hFE;
    localparam logic [7:0] D2_ADDR_B    = 8'hFD;
    localparam logic [7:0] D2_ADDR_C    = 8'h00;

    localparam logic [7:0] HANDLER_STD   = 8'd1;
    localparam logic [7:0] HANDLER_HIRES = 8'd2;
    localparam logic [7:0] HANDLER_EXT   = 8'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_SCALE   = 2'd0;
    localparam logic [1:0] CFG_EXT     = 2'd1;
    localparam logic [1:0] CFG_HANDLER = 2'd2;

    localparam logic [3:0]         RESET_ADDR    = 4'd3;
    localparam logic [SCALE_W-1:0] RESET_SCALE   = 8'd1;
    localparam logic [7:0]         RESET_HANDLER = 8'd1;

    // extended info reply, byte 0 goes out first
    localparam logic [REPLY_MAX-1:0][7:0] EXT_INFO =
        {8'd2, 8'd0, 8'd100, 8'd0, 8'h6C, 8'h70, 8'h70, 8'h61};

    // reply handed to the output buffer; count of zero means empty reply
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic [REPLY_MAX-1:0][7:0]  data;
    } reply_load_t;

endpackage

[rtl/adbm_reply_buf.sv]
// Output buffer that streams one reply, one byte per word, to the result channel.
`timescale 1ns / 1ps

module adbm_reply_buf
    import adbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  reply_load_t load_data,
    output logic        load_ok,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [7:0]  m_reply_byte,
    output logic        m_reply_valid,
    output logic        m_last
);

    logic                      valid_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic                      rvalid_reg;
    logic [REPLY_MAX-1:0][7:0] data_reg;

    assign m_last        = (rem_reg == CNT_W'(1));
    assign load_ok       = !valid_reg || (m_ready && m_last);
    assign m_valid       = valid_reg;
    assign m_reply_byte  = data_reg[0];
    assign m_reply_valid = rvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            rem_reg    <= '0;
            rvalid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            if (load_data.count == '0) begin
                rem_reg    <= CNT_W'(1);
                rvalid_reg <= 1'b0;
            end else begin
                rem_reg    <= load_data.count;
                rvalid_reg <= 1'b1;
            end
        end else if (valid_reg && m_ready) begin
            // advance to the next byte, drop out after the last one
            rem_reg <= rem_reg - CNT_W'(1);
            if (m_last) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data.data;
        end else if (valid_reg && m_ready) begin
            data_reg <= {8'd0, data_reg[REPLY_MAX-1:1]};
        end
    end

endmodule

[rtl/adb_mouse_device_core.sv]
// Top level of the bus mouse device: event decode, state and bus command handling.
`timescale 1ns / 1ps

//  channel   direction  handshake              word
//  s_        in         s_valid / s_ready      one event or bus command
//  m_        out        m_valid / m_ready      one reply byte (or an empty marker)
//  cfg_      in         cfg_valid / cfg_ready  register index and data
//
//  An accepted word is held in the input register; its state update is done as its
//  reply is loaded into the output buffer. A word yields 1 to 8 result words, so
//  input is taken every cycle for events while m_ready is high, and an N-byte talk
//  reply holds off the next word until its last byte is taken.
//  A stalled m_ready holds the reply buffer and, once the input register is full,
//  holds s_ready low. aresetn is synchronous and active low; cfg_ready is always high.

module adb_mouse_device_core
    import adbm_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // event / command channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic                       s_axis,
    input  logic signed [MOTION_W-1:0] s_motion,
    input  logic [1:0]                 s_button,
    input  logic                       s_pressed,
    input  logic [7:0]                 s_command_byte,
    input  logic [7:0]                 s_data_one,
    input  logic [7:0]                 s_data_two,
    input  logic [3:0]                 s_length,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_reply_byte,
    output logic                       m_reply_valid,
    output logic                       m_last,
    output logic                       m_has_data,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data
);

    // Sum width covers the widest scaled delta plus a guard bit for saturation.
    localparam int SUM_W = ((ACCUM_WIDTH > DELTA_W) ? ACCUM_WIDTH : DELTA_W) + 1;
    localparam logic signed [SUM_W-1:0] ACC_MAX =
        SUM_W'((64'sd1 <<< (ACCUM_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [ACCUM_WIDTH-1:0] LIM_POS = ACCUM_WIDTH'(REPORT_LIMIT);
    localparam logic signed [ACCUM_WIDTH-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [MOTION_W-1:0] MOTION_LIMIT = MOTION_W'(256);

    // Input register
    logic                       in_valid_reg;
    logic [1:0]                 cmd_reg;
    logic                       axis_reg;
    logic signed [MOTION_W-1:0] motion_reg;
    logic [1:0]                 button_reg;
    logic                       pressed_reg;
    logic [7:0]                 cb_reg;
    logic [7:0]                 d1_reg;
    logic [7:0]                 d2_reg;
    logic [3:0]                 len_reg;

    // Device state and configuration
    logic signed [ACCUM_WIDTH-1:0] ax_reg, ax_next;
    logic signed [ACCUM_WIDTH-1:0] ay_reg, ay_next;
    logic [1:0]                    btn_reg, btn_next;
    logic [1:0]                    rep_btn_reg, rep_btn_next;
    logic                          polled_reg, polled_next;
    logic [3:0]                    addr_reg, addr_next;
    logic [7:0]                    handler_reg, handler_next;
    logic [SCALE_W-1:0]            scale_reg, scale_next;
    logic                          ext_en_reg, ext_en_next;

    // Datapath
    logic                          load_ok;
    logic                          proc;
    reply_load_t                   load_data;
    logic signed [DELTA_W-1:0]     delta;
    logic                          motion_ok;
    logic signed [ACCUM_WIDTH-1:0] acc_sel;
    logic signed [SUM_W-1:0]       sum_w;
    logic signed [ACCUM_WIDTH-1:0] sat_val;
    logic                          pending_now;
    logic signed [6:0]             rx, ry;
    logic signed [ACCUM_WIDTH-1:0] rem_x, rem_y;
    logic [7:0]                    byte_x, byte_y;

    function automatic logic signed [6:0] clamp_report(
        input logic signed [ACCUM_WIDTH-1:0] v
    );
        logic signed [6:0] r;
        if (v > LIM_POS) begin
            r = 7'sd63;
        end else if (v < LIM_NEG) begin
            r = -7'sd63;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    // Take a new word whenever the register is empty or drains this cycle.
    assign proc      = in_valid_reg && load_ok;
    assign s_ready   = !in_valid_reg || load_ok;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            axis_reg    <= s_axis;
            motion_reg  <= s_motion;
            button_reg  <= s_button;
            pressed_reg <= s_pressed;
            cb_reg      <= s_command_byte;
            d1_reg      <= s_data_one;
            d2_reg      <= s_data_two;
            len_reg     <= s_length;
        end
    end

    // Motion: a delta within +-256 is scaled and added with saturation.
    assign motion_ok = (motion_reg <= MOTION_LIMIT) && (motion_reg >= -MOTION_LIMIT);
    assign delta     = $signed(motion_reg[MOTION_SEL_W-1:0]) * $signed({1'b0, scale_reg});
    assign acc_sel   = axis_reg ? ay_reg : ax_reg;
    assign sum_w     = SUM_W'(acc_sel) + SUM_W'(delta);

    always_comb begin
        if (sum_w > ACC_MAX) begin
            sat_val = ACC_MAX[ACCUM_WIDTH-1:0];
        end else if (sum_w < ACC_MIN) begin
            sat_val = ACC_MIN[ACCUM_WIDTH-1:0];
        end else begin
            sat_val = sum_w[ACCUM_WIDTH-1:0];
        end
    end

    // Something to report: never polled, buttons moved, or motion left over.
    assign pending_now = !polled_reg || (rep_btn_reg != btn_reg) ||
                         (ax_reg != '0) || (ay_reg != '0);

    // Talk register 0: report +-63 per axis and keep at most +-63 of remainder.
    assign rx     = clamp_report(ax_reg);
    assign ry     = clamp_report(ay_reg);
    assign rem_x  = ax_reg - ACCUM_WIDTH'(rx);
    assign rem_y  = ay_reg - ACCUM_WIDTH'(ry);
    assign byte_x = {~btn_reg[1], rx[6:0]};
    assign byte_y = {~btn_reg[0] & polled_reg, ry[6:0]};

    always_comb begin
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        btn_next     = btn_reg;
        rep_btn_next = rep_btn_reg;
        polled_next  = polled_reg;
        addr_next    = addr_reg;
        handler_next = handler_reg;
        scale_next   = scale_reg;
        ext_en_next  = ext_en_reg;
        load_data    = '0;

        if (proc) begin
            case (cmd_reg)
                CMD_MOTION: begin
                    if (motion_ok) begin
                        if (axis_reg) begin
                            ay_next = sat_val;
                        end else begin
                            ax_next = sat_val;
                        end
                    end
                end
                CMD_BUTTON: begin
                    if (button_reg == BTN_LEFT || button_reg == BTN_RIGHT) begin
                        btn_next[button_reg[0]] = pressed_reg;
                    end
                end
                CMD_BUS: begin
                    if (cb_reg[3:0] == FLUSH_CODE) begin
                        ax_next = '0;
                        ay_next = '0;
                    end else begin
                        case (cb_reg[3:2])
                            KIND_LISTEN: begin
                                if (cb_reg[1:0] == REG_ID && len_reg == LISTEN_LEN) begin
                                    if (d2_reg inside {D2_ADDR_A, D2_ADDR_B, D2_ADDR_C}) begin
                                        addr_next = d1_reg[3:0];
                                    end else if (d2_reg inside {HANDLER_STD, HANDLER_HIRES}
                                                 || (d2_reg == HANDLER_EXT && ext_en_reg)) begin
                                        handler_next = d2_reg;
                                    end
                                end
                            end
                            KIND_TALK: begin
                                case (cb_reg[1:0])
                                    REG_DATA: begin
                                        if (pending_now) begin
                                            polled_next       = 1'b1;
                                            ax_next           = ACCUM_WIDTH'(clamp_report(rem_x));
                                            ay_next           = ACCUM_WIDTH'(clamp_report(rem_y));
                                            // first poll: fake a left press, report
                                            // the real state on the next poll
                                            rep_btn_next      = polled_reg ? btn_reg
                                                                           : (btn_reg ^ 2'b01);
                                            load_data.count   = CNT_W'(2);
                                            load_data.data[0] = byte_y;
                                            load_data.data[1] = byte_x;
                                        end
                                    end
                                    REG_INFO: begin
                                        if (handler_reg == HANDLER_EXT) begin
                                            load_data.count = CNT_W'(REPLY_MAX);
                                            load_data.data  = EXT_INFO;
                                        end
                                    end
                                    REG_ID: begin
                                        load_data.count   = CNT_W'(2);
                                        load_data.data[0] = {4'd0, addr_reg};
                                        load_data.data[1] = handler_reg;
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE:   scale_next   = cfg_data;
                CFG_EXT:     ext_en_next  = cfg_data[0];
                CFG_HANDLER: handler_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg      <= '0;
            ay_reg      <= '0;
            btn_reg     <= '0;
            rep_btn_reg <= '0;
            polled_reg  <= 1'b0;
            addr_reg    <= RESET_ADDR;
            handler_reg <= RESET_HANDLER;
            scale_reg   <= RESET_SCALE;
            ext_en_reg  <= 1'b0;
        end else begin
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            btn_reg     <= btn_next;
            rep_btn_reg <= rep_btn_next;
            polled_reg  <= polled_next;
            addr_reg    <= addr_next;
            handler_reg <= handler_next;
            scale_reg   <= scale_next;
            ext_en_reg  <= ext_en_next;
        end
    end

    // State registers always hold the state after the word being replied to,
    // so the pending flag is read straight from them.
    assign m_has_data = pending_now;

    adbm_reply_buf u_reply (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (proc),
        .load_data     (load_data),
        .load_ok       (load_ok),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_reply_byte  (m_reply_byte),
        .m_reply_valid (m_reply_valid),
        .m_last        (m_last)
    );

endmodule

[rtl/adbm_checker.sv]
// Port-level checks of the bus mouse device, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_reply_byte,
    input logic       m_reply_valid,
    input logic       m_last
);

    `ADBM_ASSERT(a_empty_is_single, m_valid && !m_reply_valid |-> m_last && m_reply_byte == 8'd0, "empty reply word must be a lone zero")
    `ADBM_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_reply_byte) && $stable(m_last), "stalled result word changed")
    `ADBM_ASSERT(a_reply_streams, m_valid && m_ready && !m_last |=> m_valid && m_reply_valid, "reply bytes must follow back to back")
    `ADBM_ASSERT(a_stall_cause, !s_ready |-> m_valid, "input held off with no result waiting")

endmodule

bind adb_mouse_device_core adbm_checker u_adbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_reply_byte  (m_reply_byte),
    .m_reply_valid (m_reply_valid),
    .m_last        (m_last)
);
